// ===== rtl/core/cpms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the closest pair midpoint search block
// depends on nothing

package cpms_pkg;

   // capacity of each point set
   localparam int MAX_POINTS = 4096;
   localparam int AddrW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CntW       = $clog2(MAX_POINTS + 1);

   // subsampling stride is max(1, count / StrideDiv)
   localparam int StrideDiv  = 300;
   localparam int RemW       = (CntW > 9) ? CntW : 9;

   localparam int CoordW     = 24;
   localparam int SqW        = 2 * CoordW;
   localparam int DistW      = SqW + 2;

   // item kinds
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } point_type;

   // operations of the shared distance unit
   typedef enum logic [2:0] {
      DOP_NONE  = 3'd0,
      DOP_CLEAR = 3'd1,
      DOP_SQ_X  = 3'd2,
      DOP_SQ_Y  = 3'd3,
      DOP_SQ_Z  = 3'd4,
      DOP_CMP   = 3'd5,
      DOP_TAKE  = 3'd6
   } dop_type;

   typedef struct packed {
      dop_type op;
      logic    a_ok;
      logic    b_ok;
   } dctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/cpms_point_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// point store for one set: one write port, one registered read port
// depends on cpms_pkg

module cpms_point_mem (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [cpms_pkg::AddrW-1:0] wr_addr,
   input  wire cpms_pkg::point_type        wr_data,
   input  wire logic [cpms_pkg::AddrW-1:0] rd_addr,
   output cpms_pkg::point_type             rd_data
);
   import cpms_pkg::*;

   point_type mem [MAX_POINTS];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cpms_sqdist.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared squared distance unit: one squarer used per axis, accumulator,
// running best compare and midpoint of the best pair
// depends on cpms_pkg

module cpms_sqdist (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cpms_pkg::dctl_type         ctl,
   input  wire cpms_pkg::point_type        pt_a,
   input  wire cpms_pkg::point_type        pt_b,
   output logic [cpms_pkg::CoordW-1:0]     mid_x,
   output logic [cpms_pkg::CoordW-1:0]     mid_y,
   output logic [cpms_pkg::CoordW-1:0]     mid_z
);
   import cpms_pkg::*;

   logic                     have_ff, have_in;
   logic [SqW-1:0]           prod_ff, prod_in;
   logic [DistW-1:0]         acc_ff, acc_in;
   logic [DistW-1:0]         best_ff, best_in;
   logic [CoordW-1:0]        mx_ff, my_ff, mz_ff;
   logic [CoordW-1:0]        mx_in, my_in, mz_in;

   logic signed [CoordW-1:0] op_a, op_b;
   logic signed [CoordW:0]   diff;
   logic [CoordW:0]          mag;
   logic [DistW-1:0]         pair_sq;
   point_type                ka, kb;

   // floor of (a + b) / 2
   function automatic logic [CoordW-1:0] half_sum(input logic signed [CoordW-1:0] a,
                                                   input logic signed [CoordW-1:0] b);
      logic signed [CoordW:0] s;
      s = {a[CoordW-1], a} + {b[CoordW-1], b};
      return s[CoordW:1];
   endfunction

   // axis select for the squarer
   always_comb begin
      unique case (ctl.op)
         DOP_SQ_Y: begin
            op_a = pt_a.y;
            op_b = pt_b.y;
         end
         DOP_SQ_Z: begin
            op_a = pt_a.z;
            op_b = pt_b.z;
         end
         default: begin
            op_a = pt_a.x;
            op_b = pt_b.x;
         end
      endcase
   end

   assign diff    = {op_a[CoordW-1], op_a} - {op_b[CoordW-1], op_b};
   assign mag     = diff[CoordW] ? (~diff + 1'b1) : diff;
   assign pair_sq = acc_ff + DistW'(prod_ff);

   // an empty set contributes the origin
   assign ka = ctl.a_ok ? pt_a : '0;
   assign kb = ctl.b_ok ? pt_b : '0;

   always_comb begin
      have_in = have_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      best_in = best_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      mz_in   = mz_ff;
      unique case (ctl.op)
         DOP_NONE: begin
         end
         DOP_CLEAR: begin
            have_in = 1'b0;
         end
         DOP_SQ_X: begin
            prod_in = mag[CoordW-1:0] * mag[CoordW-1:0];
            acc_in  = '0;
         end
         DOP_SQ_Y: begin
            prod_in = mag[CoordW-1:0] * mag[CoordW-1:0];
            acc_in  = DistW'(prod_ff);
         end
         DOP_SQ_Z: begin
            prod_in = mag[CoordW-1:0] * mag[CoordW-1:0];
            acc_in  = acc_ff + DistW'(prod_ff);
         end
         DOP_CMP: begin
            // strict less keeps the first pair on a tie
            if (!have_ff || (pair_sq < best_ff)) begin
               have_in = 1'b1;
               best_in = pair_sq;
               mx_in   = half_sum(pt_a.x, pt_b.x);
               my_in   = half_sum(pt_a.y, pt_b.y);
               mz_in   = half_sum(pt_a.z, pt_b.z);
            end
         end
         DOP_TAKE: begin
            mx_in = half_sum(ka.x, kb.x);
            my_in = half_sum(ka.y, kb.y);
            mz_in = half_sum(ka.z, kb.z);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      best_ff <= best_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mz_ff   <= mz_in;
   end

   assign mid_x = mx_ff;
   assign mid_y = my_ff;
   assign mid_z = mz_ff;

endmodule

`default_nettype wire

// ===== rtl/core/closest_pair_midpoint_search_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// top level of the closest pair midpoint search block: sequencer, set counts,
// stride division and output register; depends on cpms_pkg, cpms_point_mem, cpms_sqdist

// Two 3-D point sets of up to MAX_POINTS points each are loaded one item per
// cycle while the block is idle (kind 0 to set A, kind 1 to set B); a load
// into a full set is dropped and remembered in the dropped flag. A search item
// (kind 2) subsamples each set with stride max(1, count/300), scans every
// subsampled (A, B) pair with A outer and B inner, keeps the pair of smallest
// squared distance (first one on a tie) and returns its midpoint, rounded
// toward minus infinity, then empties both sets. An empty set contributes the
// origin and the other set its first point. Kind 3 is ignored. A search first
// runs the stride division (one subtract of 300 per cycle, both sets side by
// side), then per scanned pair one memory fetch, three passes of the single
// squarer for x, y and z and one compare, and last posts the result once the
// output register is free; with an empty set the scan is replaced by one fetch
// and the take of the midpoint. The block stalls its input for the whole
// search. A finished result sits in an output register, so loads are taken
// while it waits to be collected.

module closest_pair_midpoint_search_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_kind,
   input  wire logic signed [23:0]          req_px,
   input  wire logic signed [23:0]          req_py,
   input  wire logic signed [23:0]          req_pz,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [23:0]               rsp_mid_x,
   output logic signed [23:0]               rsp_mid_y,
   output logic signed [23:0]               rsp_mid_z,
   output logic                             rsp_dropped
);
   import cpms_pkg::*;

   // sequencer states
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DIV   = 9'b000000010,
      S_FETCH = 9'b000000100,
      S_SQX   = 9'b000001000,
      S_SQY   = 9'b000010000,
      S_SQZ   = 9'b000100000,
      S_CMP   = 9'b001000000,
      S_EMPTY = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   localparam logic [CntW-1:0] CntMax  = CntW'(MAX_POINTS);
   localparam logic [RemW-1:0] DivStep = RemW'(StrideDiv);

   state_type         state_ff, state_in;
   logic [CntW-1:0]   cnt_a_ff, cnt_a_in;
   logic [CntW-1:0]   cnt_b_ff, cnt_b_in;
   logic              ovf_ff, ovf_in;
   logic [RemW-1:0]   rem_a_ff, rem_a_in;
   logic [RemW-1:0]   rem_b_ff, rem_b_in;
   logic [CntW-1:0]   stride_a_ff, stride_a_in;
   logic [CntW-1:0]   stride_b_ff, stride_b_in;
   logic [AddrW-1:0]  ia_ff, ia_in;
   logic [AddrW-1:0]  ib_ff, ib_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CoordW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [CoordW-1:0] rsp_x_in, rsp_y_in, rsp_z_in;
   logic              rsp_drop_ff, rsp_drop_in;

   logic              req_fire;
   logic              wr_a, wr_b;
   logic              a_full, b_full;
   logic              any_empty;
   logic              out_free;
   logic [CntW:0]     ia_next, ib_next;
   point_type         wr_pt;
   point_type         pt_a, pt_b;
   dctl_type          dctl;
   logic [CoordW-1:0] mid_x, mid_y, mid_z;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;

   assign a_full    = (cnt_a_ff == CntMax);
   assign b_full    = (cnt_b_ff == CntMax);
   assign wr_a      = req_fire && (req_kind == KIND_LOAD_A) && !a_full;
   assign wr_b      = req_fire && (req_kind == KIND_LOAD_B) && !b_full;
   assign wr_pt     = '{x: req_px, y: req_py, z: req_pz};

   assign any_empty = (cnt_a_ff == '0) || (cnt_b_ff == '0);
   // the output register can take a new result this cycle
   assign out_free  = !(rsp_valid_ff && rsp_stall);

   // index advance, one bit wider so the end of the set is seen
   assign ia_next   = {1'b0, CntW'(ia_ff)} + {1'b0, stride_a_ff};
   assign ib_next   = {1'b0, CntW'(ib_ff)} + {1'b0, stride_b_ff};

   cpms_point_mem u_mem_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[AddrW-1:0]),
      .wr_data (wr_pt),
      .rd_addr (ia_ff),
      .rd_data (pt_a)
   );

   cpms_point_mem u_mem_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[AddrW-1:0]),
      .wr_data (wr_pt),
      .rd_addr (ib_ff),
      .rd_data (pt_b)
   );

   cpms_sqdist u_sqdist (
      .clock (clock),
      .reset (reset),
      .ctl   (dctl),
      .pt_a  (pt_a),
      .pt_b  (pt_b),
      .mid_x (mid_x),
      .mid_y (mid_y),
      .mid_z (mid_z)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ovf_in       = ovf_ff;
      rem_a_in     = rem_a_ff;
      rem_b_in     = rem_b_ff;
      stride_a_in  = stride_a_ff;
      stride_b_in  = stride_b_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_drop_in  = rsp_drop_ff;
      dctl         = '{op: DOP_NONE, a_ok: cnt_a_ff != '0, b_ok: cnt_b_ff != '0};

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (wr_a) begin
                  cnt_a_in = cnt_a_ff + 1'b1;
               end
               if (wr_b) begin
                  cnt_b_in = cnt_b_ff + 1'b1;
               end
               if (((req_kind == KIND_LOAD_A) && a_full) ||
                   ((req_kind == KIND_LOAD_B) && b_full)) begin
                  ovf_in = 1'b1;
               end
               if (req_kind == KIND_SEARCH) begin
                  rem_a_in    = RemW'(cnt_a_ff);
                  rem_b_in    = RemW'(cnt_b_ff);
                  stride_a_in = '0;
                  stride_b_in = '0;
                  state_in    = S_DIV;
               end
            end
         end
         S_DIV: begin
            // count / 300 by repeated subtraction, both sets side by side
            dctl.op = DOP_CLEAR;
            if (rem_a_ff >= DivStep) begin
               rem_a_in    = rem_a_ff - DivStep;
               stride_a_in = stride_a_ff + 1'b1;
            end
            if (rem_b_ff >= DivStep) begin
               rem_b_in    = rem_b_ff - DivStep;
               stride_b_in = stride_b_ff + 1'b1;
            end
            if ((rem_a_ff < DivStep) && (rem_b_ff < DivStep)) begin
               if (stride_a_ff == '0) begin
                  stride_a_in = CntW'(1);
               end
               if (stride_b_ff == '0) begin
                  stride_b_in = CntW'(1);
               end
               ia_in    = '0;
               ib_in    = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = any_empty ? S_EMPTY : S_SQX;
         end
         S_SQX: begin
            dctl.op  = DOP_SQ_X;
            state_in = S_SQY;
         end
         S_SQY: begin
            dctl.op  = DOP_SQ_Y;
            state_in = S_SQZ;
         end
         S_SQZ: begin
            dctl.op  = DOP_SQ_Z;
            state_in = S_CMP;
         end
         S_CMP: begin
            dctl.op = DOP_CMP;
            if (ib_next < {1'b0, cnt_b_ff}) begin
               ib_in    = ib_next[AddrW-1:0];
               state_in = S_FETCH;
            end else if (ia_next < {1'b0, cnt_a_ff}) begin
               ib_in    = '0;
               ia_in    = ia_next[AddrW-1:0];
               state_in = S_FETCH;
            end else begin
               state_in = S_DONE;
            end
         end
         S_EMPTY: begin
            dctl.op  = DOP_TAKE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = mid_x;
               rsp_y_in     = mid_y;
               rsp_z_in     = mid_z;
               rsp_drop_in  = ovf_ff;
               cnt_a_in     = '0;
               cnt_b_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_a_ff    <= rem_a_in;
      rem_b_ff    <= rem_b_in;
      stride_a_ff <= stride_a_in;
      stride_b_ff <= stride_b_in;
      ia_ff       <= ia_in;
      ib_ff       <= ib_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_mid_x   = rsp_x_ff;
   assign rsp_mid_y   = rsp_y_ff;
   assign rsp_mid_z   = rsp_z_ff;
   assign rsp_dropped = rsp_drop_ff;

   // set counts never pass capacity
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CntMax) && (cnt_b_ff <= CntMax))
      else $error("set count above capacity");

   // the pair scan only compares points that were loaded
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (CntW'(ia_ff) < cnt_a_ff) && (CntW'(ib_ff) < cnt_b_ff))
      else $error("pair index outside loaded points");

   // strides are settled to at least one before the scan starts
   a_stride_nz: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> (stride_a_ff != '0) && (stride_b_ff != '0))
      else $error("zero stride during scan");

   // posting a result empties both sets and raises the output
   a_post_clear: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && out_free) |=>
         rsp_valid_ff && (cnt_a_ff == '0) && (cnt_b_ff == '0) && !ovf_ff &&
         (state_ff == S_IDLE))
      else $error("result posted without clearing the sets");

endmodule

`default_nettype wire

// ===== dv/closest_pair_midpoint_search_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for closest_pair_midpoint_search_top: loads point sets, runs
// searches and checks each midpoint against a predictor; depends on cpms_pkg and the rtl

module closest_pair_midpoint_search_top_tb;
   import cpms_pkg::*;

   // kind 3 has no meaning and must leave the block untouched
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic signed [CoordW-1:0] COORD_MAX = 24'h7FFFFF;
   localparam logic signed [CoordW-1:0] COORD_MIN = 24'h800000;
   localparam int RANDOM_ITEMS = 500;
   localparam int PRINT_CAP = 100;

   typedef struct {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic dropped;
   } midpoint_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_kind;
   logic signed [CoordW-1:0] req_px, req_py, req_pz;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [CoordW-1:0] rsp_mid_x, rsp_mid_y, rsp_mid_z;
   logic rsp_dropped;

   // predictor state: the points each set holds and the pending drop flag
   point_type loaded_a[$];
   point_type loaded_b[$];
   bit drop_pending;
   midpoint_type pending_midpoints[$];

   int mismatches = 0;
   int items_accepted = 0;
   int midpoints_checked = 0;
   int dropped_searches = 0;
   bit no_idle = 1'b0;

   closest_pair_midpoint_search_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_px      (req_px),
      .req_py      (req_py),
      .req_pz      (req_pz),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_mid_x   (rsp_mid_x),
      .rsp_mid_y   (rsp_mid_y),
      .rsp_mid_z   (rsp_mid_z),
      .rsp_dropped (rsp_dropped)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic point_type make_point(input logic signed [CoordW-1:0] x,
                                            input logic signed [CoordW-1:0] y,
                                            input logic signed [CoordW-1:0] z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      return p;
   endfunction

   function automatic longint axis_sq(input logic signed [CoordW-1:0] a,
                                      input logic signed [CoordW-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
   endfunction

   // (a + b) >>> 1 on a wide signed sum floors toward minus infinity
   function automatic logic signed [CoordW-1:0] halve_sum(input logic signed [CoordW-1:0] a,
                                                         input logic signed [CoordW-1:0] b);
      longint s;
      s = (longint'(a) + longint'(b)) >>> 1;
      return s[CoordW-1:0];
   endfunction

   function automatic midpoint_type predict_search_midpoint();
      int step_a, step_b, i, k;
      longint best_dist, pair_sq;
      bit found;
      point_type pick_a, pick_b;
      midpoint_type m;
      step_a = loaded_a.size() / StrideDiv;
      step_b = loaded_b.size() / StrideDiv;
      if (step_a == 0) step_a = 1;
      if (step_b == 0) step_b = 1;
      // an empty set contributes the origin, the other set its first point
      pick_a = '0;
      pick_b = '0;
      if (loaded_a.size() > 0) pick_a = loaded_a[0];
      if (loaded_b.size() > 0) pick_b = loaded_b[0];
      found = 1'b0;
      best_dist = 0;
      // a outer, b inner; strict less-than keeps the first pair on a tie
      for (i = 0; i < loaded_a.size(); i += step_a) begin
         for (k = 0; k < loaded_b.size(); k += step_b) begin
            pair_sq = axis_sq(loaded_a[i].x, loaded_b[k].x)
                    + axis_sq(loaded_a[i].y, loaded_b[k].y)
                    + axis_sq(loaded_a[i].z, loaded_b[k].z);
            if (!found || pair_sq < best_dist) begin
               found = 1'b1;
               best_dist = pair_sq;
               pick_a = loaded_a[i];
               pick_b = loaded_b[k];
            end
         end
      end
      m.x = halve_sum(pick_a.x, pick_b.x);
      m.y = halve_sum(pick_a.y, pick_b.y);
      m.z = halve_sum(pick_a.z, pick_b.z);
      m.dropped = drop_pending;
      return m;
   endfunction

   function automatic void apply_item(input logic [1:0] kind, input point_type p);
      midpoint_type m;
      case (kind)
         KIND_LOAD_A: begin
            if (loaded_a.size() >= MAX_POINTS) drop_pending = 1'b1;
            else loaded_a = {loaded_a, p};
         end
         KIND_LOAD_B: begin
            if (loaded_b.size() >= MAX_POINTS) drop_pending = 1'b1;
            else loaded_b = {loaded_b, p};
         end
         KIND_SEARCH: begin
            m = predict_search_midpoint();
            if (m.dropped) dropped_searches++;
            pending_midpoints = {pending_midpoints, m};
            loaded_a.delete();
            loaded_b.delete();
            drop_pending = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // every accepted item goes through the predictor in order
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         items_accepted++;
         apply_item(req_kind, make_point(req_px, req_py, req_pz));
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
   endtask

   always @(posedge clock) begin
      midpoint_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_midpoints.size() == 0) begin
            report_mismatch($sformatf("unexpected midpoint (%0d, %0d, %0d) dropped=%0b",
                                      rsp_mid_x, rsp_mid_y, rsp_mid_z, rsp_dropped));
         end else begin
            want = pending_midpoints.pop_front();
            midpoints_checked++;
            if (rsp_mid_x !== want.x)
               report_mismatch($sformatf("mid_x got %0d want %0d", rsp_mid_x, want.x));
            if (rsp_mid_y !== want.y)
               report_mismatch($sformatf("mid_y got %0d want %0d", rsp_mid_y, want.y));
            if (rsp_mid_z !== want.z)
               report_mismatch($sformatf("mid_z got %0d want %0d", rsp_mid_z, want.z));
            if (rsp_dropped !== want.dropped)
               report_mismatch($sformatf("dropped got %0b want %0b", rsp_dropped, want.dropped));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   // flavors: 0 full range, 1 tight cluster (ties), 2 extremes, 3 medium spread
   function automatic logic signed [CoordW-1:0] pick_coord(input int flavor);
      logic [31:0] raw;
      int v;
      case (flavor)
         1: v = int'($urandom_range(0, 8)) - 4;
         2: begin
            case ($urandom_range(0, 4))
               0: v = COORD_MAX;
               1: v = COORD_MIN;
               2: v = -1;
               3: v = 0;
               default: v = 1;
            endcase
         end
         3: v = int'($urandom_range(0, 4000)) - 2000;
         default: begin
            raw = $urandom();
            v = int'(raw);
         end
      endcase
      return v[CoordW-1:0];
   endfunction

   // flavor 4 mixes the others coordinate by coordinate
   function automatic point_type pick_point(input int flavor);
      if (flavor == 4)
         return make_point(pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)),
                           pick_coord($urandom_range(0, 3)));
      return make_point(pick_coord(flavor), pick_coord(flavor), pick_coord(flavor));
   endfunction

   // mostly back to back or short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // drive at the falling edge, hold until accepted at a rising edge
   task automatic send_item(input logic [1:0] kind, input point_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_kind = kind;
      req_px = p.x;
      req_py = p.y;
      req_pz = p.z;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic load_set(input logic [1:0] kind, input int count, input int flavor);
      repeat (count) send_item(kind, pick_point(flavor));
   endtask

   // coordinates of a search item are ignored, so they are random noise
   task automatic search_and_clear();
      send_item(KIND_SEARCH, pick_point(0));
   endtask

   // result side: open stretches alternate with stalls, mostly short
   initial begin
      rsp_stall = 1'b0;
      forever begin
         rsp_stall = 1'b0;
         repeat ($urandom_range(1, 30)) @(negedge clock);
         rsp_stall = 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(negedge clock);
         else repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   end

   // ---------------------------------------------------------------- tests

   // full-scale coordinates, midpoint rounding, the unused kind
   task automatic test_extremes_and_rounding();
      send_item(KIND_UNUSED, pick_point(0));
      search_and_clear();
      send_item(KIND_LOAD_A, make_point(COORD_MAX, COORD_MAX, COORD_MAX));
      send_item(KIND_LOAD_B, make_point(COORD_MAX, COORD_MAX, COORD_MAX));
      search_and_clear();
      send_item(KIND_LOAD_A, make_point(COORD_MIN, COORD_MIN, COORD_MIN));
      send_item(KIND_LOAD_B, make_point(COORD_MIN, COORD_MIN, COORD_MIN));
      search_and_clear();
      // sum of -1 must floor to -1, not truncate to 0
      send_item(KIND_LOAD_A, make_point(COORD_MAX, COORD_MIN, COORD_MAX));
      send_item(KIND_LOAD_B, make_point(COORD_MIN, COORD_MAX, COORD_MIN));
      search_and_clear();
      send_item(KIND_LOAD_A, make_point(1, -1, 3));
      send_item(KIND_UNUSED, make_point(COORD_MIN, COORD_MIN, COORD_MIN));
      send_item(KIND_LOAD_B, make_point(0, 0, 0));
      search_and_clear();
   endtask

   // first pair wins a tie in both loops; one or the other set left empty
   task automatic test_ties_and_empty_sets();
      send_item(KIND_LOAD_A, make_point(0, 0, 0));
      send_item(KIND_LOAD_B, make_point(1, 0, 0));
      send_item(KIND_LOAD_B, make_point(-1, 0, 0));
      search_and_clear();
      send_item(KIND_LOAD_A, make_point(2, 0, 0));
      send_item(KIND_LOAD_A, make_point(-2, 0, 0));
      send_item(KIND_LOAD_B, make_point(0, 0, 0));
      search_and_clear();
      send_item(KIND_LOAD_B, make_point(5, 7, -9));
      send_item(KIND_LOAD_B, make_point(1, 1, 1));
      search_and_clear();
      send_item(KIND_LOAD_A, make_point(-7, 3, 0));
      send_item(KIND_LOAD_A, make_point(0, 0, 0));
      search_and_clear();
   endtask

   // a load into a full set is dropped and flagged once, then the flag clears;
   // the full set also scans with the largest stride
   task automatic test_set_overflow();
      load_set(KIND_LOAD_A, MAX_POINTS + 1, 0);
      load_set(KIND_LOAD_B, 1, 0);
      search_and_clear();
      search_and_clear();
   endtask

   // a set size where the subsampling stride steps up to two
   task automatic test_stride_boundaries();
      load_set(KIND_LOAD_A, 2 * StrideDiv, 3);
      load_set(KIND_LOAD_B, $urandom_range(1, 3), 3);
      search_and_clear();
   endtask

   // random small sets with interleaved loads, noise items and occasional empties
   task automatic test_random_episodes(input int item_goal);
      int sent, na, nb, flavor, r;
      sent = 0;
      while (sent < item_goal) begin
         no_idle = ($urandom_range(0, 7) == 0);
         flavor = $urandom_range(0, 4);
         r = $urandom_range(0, 19);
         na = (r == 0 || r == 2) ? 0 : $urandom_range(1, 12);
         nb = (r == 1 || r == 2) ? 0 : $urandom_range(1, 12);
         while (na + nb > 0) begin
            if ($urandom_range(0, 9) == 0) send_item(KIND_UNUSED, pick_point(0));
            if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 1)) begin
               send_item(KIND_LOAD_A, pick_point(flavor));
               na--;
            end else begin
               send_item(KIND_LOAD_B, pick_point(flavor));
               nb--;
            end
            sent++;
         end
         search_and_clear();
         sent++;
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- run

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_LOAD_A;
      req_px = '0;
      req_py = '0;
      req_pz = '0;
      drop_pending = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_extremes_and_rounding();
      test_ties_and_empty_sets();
      test_set_overflow();
      test_stride_boundaries();
      test_random_episodes(RANDOM_ITEMS);

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_midpoints.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Run covered %0d accepted items and %0d checked midpoints (%0d with dropped loads);",
               items_accepted, midpoints_checked, dropped_searches);
      $display("directed extremes, ties, empty sets, a full set and a stride step, then random sets.");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog, well beyond the slowest correct run
   initial begin
      #20000000;
      $display("Timeout with %0d midpoints still pending", pending_midpoints.size());
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cpms_pkg.sv
rtl/core/cpms_point_mem.sv
rtl/core/cpms_sqdist.sv
rtl/core/closest_pair_midpoint_search_top.sv
dv/closest_pair_midpoint_search_top_tb.sv
